// ===== design/assert_macros.svh =====
// Assertion macros used by the cipher controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/aesctr_pkg.sv =====
// Package with shared types, constants and functions of the AES-128 CTR cipher.
package aesctr_pkg;

   localparam int unsigned DataWidth = 8;
   localparam int unsigned CsrWidth = 64;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned NumRounds = 10;

   localparam logic [CsrIndexWidth-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_LOW = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_NONCE_HIGH = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_NONCE_LOW = 2'd3;

   typedef struct packed {
      logic load;      // Load key and counter from the registers, reset byte position.
      logic start;     // Begin encrypting the current counter.
      logic step;      // Consume one byte of keystream.
      logic finish;    // Close the message.
   } dp_cmd_type;

   typedef struct packed {
      logic busy;      // The round unit is working on a block.
      logic ks_ready;  // Keystream for the current block is valid.
   } dp_status_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

// ===== design/aesctr_datapath.sv =====
// Datapath of the cipher: round-iterative AES core with on-the-fly key schedule and counter.
module aesctr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [127:0]                      key,
   input  logic [127:0]                      nonce,
   input  aesctr_pkg::dp_cmd_type            cmd,
   input  logic [aesctr_pkg::DataWidth-1:0]  data_byte,
   output aesctr_pkg::dp_status_type         status,
   output logic [aesctr_pkg::DataWidth-1:0]  out_byte
);
   import aesctr_pkg::*;

   logic [127:0] rkey0_ff, rkey0_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [127:0] ctr_ff, ctr_in;
   logic [127:0] state_ff, state_in;
   logic [127:0] ks_ff, ks_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   round_ff, round_in;
   logic         busy_ff, busy_in;
   logic         ks_valid_ff, ks_valid_in;
   logic [3:0]   pos_ff, pos_in;

   logic [127:0] next_key;
   logic [127:0] sub_shift;
   logic [127:0] mixed;
   logic [31:0]  rot_word;

   always_comb begin
      logic [31:0] w0, w1, w2, w3;
      w3 = rkey_ff[31:0];
      rot_word = {sbox(w3[23:16]) ^ rcon_ff, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = rkey_ff[127:96] ^ rot_word;
      w1 = rkey_ff[95:64] ^ w0;
      w2 = rkey_ff[63:32] ^ w1;
      next_key = {w0, w1, w2, rkey_ff[31:0] ^ w2};
   end

   // Byte i of the block sits at bits 127-8i.
   always_comb begin
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      for (int i = 0; i < 16; i++) begin
         s[i] = sbox(state_ff[127-8*i -: 8]);
      end
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[r+4*c] = s[r+4*((c+r)%4)];
         end
      end
      for (int i = 0; i < 16; i++) begin
         sub_shift[127-8*i -: 8] = t[i];
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c];
         a1 = t[4*c+1];
         a2 = t[4*c+2];
         a3 = t[4*c+3];
         mixed[127-32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         mixed[119-32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         mixed[111-32*c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         mixed[103-32*c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
   end

   always_comb begin
      rkey0_in = rkey0_ff;
      rkey_in = rkey_ff;
      ctr_in = ctr_ff;
      state_in = state_ff;
      ks_in = ks_ff;
      rcon_in = rcon_ff;
      round_in = round_ff;
      busy_in = busy_ff;
      ks_valid_in = ks_valid_ff;
      pos_in = pos_ff;
      if (cmd.load) begin
         rkey0_in = key;
         ctr_in = nonce;
         pos_in = '0;
         ks_valid_in = 1'b0;
      end
      if (cmd.start) begin
         state_in = ctr_ff ^ rkey0_ff;
         rkey_in = rkey0_ff;
         rcon_in = 8'h01;
         round_in = 4'd1;
         busy_in = 1'b1;
         ks_valid_in = 1'b0;
      end else if (busy_ff) begin
         if (round_ff == 4'(NumRounds)) begin
            ks_in = sub_shift ^ next_key;
            busy_in = 1'b0;
            ks_valid_in = 1'b1;
         end else begin
            state_in = mixed ^ next_key;
         end
         rkey_in = next_key;
         rcon_in = xtime(rcon_ff);
         round_in = round_ff + 4'd1;
      end
      if (cmd.step) begin
         pos_in = pos_ff + 4'd1;
         if (pos_ff == 4'd15) begin
            ctr_in = ctr_ff + 128'd1;
            ks_valid_in = 1'b0;
         end
      end
      if (cmd.finish) begin
         pos_in = '0;
         ks_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ks_valid_ff <= 1'b0;
         pos_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         ks_valid_ff <= ks_valid_in;
         pos_ff <= pos_in;
      end
      rkey0_ff <= rkey0_in;
      rkey_ff <= rkey_in;
      ctr_ff <= ctr_in;
      state_ff <= state_in;
      ks_ff <= ks_in;
      rcon_ff <= rcon_in;
      round_ff <= round_in;
   end

   assign status.busy = busy_ff;
   assign status.ks_ready = ks_valid_ff;
   assign out_byte = data_byte ^ ks_ff[127 - 8*pos_ff -: 8];

endmodule

// ===== design/aesctr_control.sv =====
// Controller of the cipher: message framing and byte handshake sequencing.
`include "assert_macros.svh"
module aesctr_control (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_final,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  aesctr_pkg::dp_status_type  status,
   output aesctr_pkg::dp_cmd_type     cmd,
   output logic                       take
);
   import aesctr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_RUN,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      cmd = '0;
      take = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.ks_ready && req_valid) begin
               take = 1'b1;
               last_in = req_final;
               state_in = ST_OUT;
            end else if (!status.ks_ready && !status.busy) begin
               state_in = ST_START;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               cmd.step = 1'b1;
               cmd.finish = last_ff;
               state_in = last_ff ? ST_IDLE : ST_RUN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
      end
   end

   assign req_stall = !(state_ff == ST_RUN && status.ks_ready);
   assign rsp_valid = (state_ff == ST_OUT);

   `ASSERT_IMPLY(a_take_needs_ks, clock, reset, take, status.ks_ready && !status.busy)
   `ASSERT_NEXT(a_take_goes_out, clock, reset, take, state_ff == ST_OUT)
   `ASSERT_IMPLY(a_no_start_busy, clock, reset, cmd.start, !status.busy)

endmodule

// ===== design/aes128_ctr_stream_cipher.sv =====
// Top level of the byte-serial AES-128 counter-mode stream cipher.
// Each byte is accepted and then delivered while keystream is on hand. The first byte of
// every 16-byte block, and so the first byte of every message, is held off while the
// controller sees that a new block is needed (at the start of a message, it loads key
// and nonce), starts the round-iterative core, and the core runs ten rounds at one round
// per cycle. The result byte is held in the input pipeline until taken, so the input stalls
// while a result is pending.
module aes128_ctr_stream_cipher (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [aesctr_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [aesctr_pkg::CsrWidth-1:0]       csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [aesctr_pkg::DataWidth-1:0]      req_data_byte,
   input  logic                                  req_final_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [aesctr_pkg::DataWidth-1:0]      rsp_out_byte,
   output logic                                  rsp_final_out
);
   import aesctr_pkg::*;

   logic [CsrWidth-1:0] key_high_ff, key_low_ff, nonce_high_ff, nonce_low_ff;
   logic [DataWidth-1:0] data_ff, out_byte;
   logic final_ff;
   dp_cmd_type cmd;
   dp_status_type status;
   logic take;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
         nonce_high_ff <= '0;
         nonce_low_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW: key_low_ff <= csr_data;
            CSR_NONCE_HIGH: nonce_high_ff <= csr_data;
            CSR_NONCE_LOW: nonce_low_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_data_byte;
         final_ff <= req_final_byte;
      end
   end

   aesctr_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_final (req_final_byte),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .take      (take)
   );

   aesctr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .key       ({key_high_ff, key_low_ff}),
      .nonce     ({nonce_high_ff, nonce_low_ff}),
      .cmd       (cmd),
      .data_byte (data_ff),
      .status    (status),
      .out_byte  (out_byte)
   );

   assign rsp_out_byte = out_byte;
   assign rsp_final_out = final_ff;

endmodule

// ===== dv/aes128_ctr_stream_cipher_test.sv =====
// Self-checking testbench for the byte-serial AES-128 counter-mode stream cipher.
`timescale 1ns / 100ps

module aes128_ctr_stream_cipher_test;
   import aesctr_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } cipher_beat_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_write;
   logic [CsrIndexWidth-1:0]  csr_index;
   logic [CsrWidth-1:0]       csr_data;
   logic                      req_valid;
   logic                      req_stall;
   logic [DataWidth-1:0]      req_data_byte;
   logic                      req_final_byte;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [DataWidth-1:0]      rsp_out_byte;
   logic                      rsp_final_out;

   cipher_beat_type pending_bytes[$];
   cipher_beat_type expected_bytes[$];
   int unsigned  send_idle_pct;
   int unsigned  recv_stall_pct;
   int unsigned  hold_left;
   int unsigned  cycle_count;
   int unsigned  error_count;

   logic [7:0]   sbox_tab[256];
   logic [63:0]  csr_shadow[4];
   logic [7:0]   round_key_bytes[176];
   logic [127:0] counter_block;
   logic [127:0] keystream_block;
   logic [3:0]   key_pos;
   logic         msg_open;

   aes128_ctr_stream_cipher u_top (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [7:0] gf_double(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = gf_double(a);
      end
      return acc;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   task automatic build_sbox();
      logic [7:0] inv;
      for (int a = 0; a < 256; a++) begin
         inv = 8'h00;
         for (int b = 1; b < 256; b++)
            if (gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
         sbox_tab[a] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                       ^ 8'h63;
      end
   endtask

   task automatic expand_key();
      logic [127:0] key;
      logic [7:0]   t[4];
      logic [7:0]   first;
      logic [7:0]   rcon;
      key = {csr_shadow[CSR_KEY_HIGH], csr_shadow[CSR_KEY_LOW]};
      rcon = 8'h01;
      for (int i = 0; i < 16; i++) round_key_bytes[i] = key[127 - 8 * i -: 8];
      for (int p = 16; p < 176; p += 4) begin
         for (int j = 0; j < 4; j++) t[j] = round_key_bytes[p - 4 + j];
         if (p % 16 == 0) begin
            first = t[0];
            t[0] = sbox_tab[t[1]] ^ rcon;
            t[1] = sbox_tab[t[2]];
            t[2] = sbox_tab[t[3]];
            t[3] = sbox_tab[first];
            rcon = gf_double(rcon);
         end
         for (int j = 0; j < 4; j++) round_key_bytes[p + j] = round_key_bytes[p - 16 + j] ^ t[j];
      end
   endtask

   task automatic encrypt_counter();
      logic [7:0] s[16];
      logic [7:0] t[16];
      logic [7:0] a0, a1, a2, a3;
      for (int i = 0; i < 16; i++) s[i] = counter_block[127 - 8 * i -: 8] ^ round_key_bytes[i];
      for (int r = 1; r <= NumRounds; r++) begin
         for (int i = 0; i < 16; i++) s[i] = sbox_tab[s[i]];
         for (int row = 0; row < 4; row++)
            for (int c = 0; c < 4; c++) t[row + 4 * c] = s[row + 4 * ((c + row) % 4)];
         s = t;
         if (r != NumRounds) begin
            for (int c = 0; c < 4; c++) begin
               a0 = s[4 * c];
               a1 = s[4 * c + 1];
               a2 = s[4 * c + 2];
               a3 = s[4 * c + 3];
               s[4 * c]     = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
               s[4 * c + 1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
               s[4 * c + 2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
               s[4 * c + 3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
            end
         end
         for (int i = 0; i < 16; i++) s[i] ^= round_key_bytes[16 * r + i];
      end
      for (int i = 0; i < 16; i++) keystream_block[127 - 8 * i -: 8] = s[i];
   endtask

   task automatic predict_cipher_byte(input logic [7:0] data, input logic last);
      cipher_beat_type res;
      if (!msg_open) begin
         expand_key();
         counter_block = {csr_shadow[CSR_NONCE_HIGH], csr_shadow[CSR_NONCE_LOW]};
         key_pos = 4'd0;
         msg_open = 1'b1;
      end
      if (key_pos == 4'd0) encrypt_counter();
      res.data = data ^ keystream_block[127 - 8 * key_pos -: 8];
      res.last = last;
      expected_bytes.push_back(res);
      key_pos = key_pos + 4'd1;
      if (key_pos == 4'd0) counter_block = counter_block + 128'd1;
      if (last) begin
         msg_open = 1'b0;
         key_pos = 4'd0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_cipher_byte(req_data_byte, req_final_byte);
            void'(pending_bytes.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data_byte <= pending_bytes[0].data;
               req_final_byte <= pending_bytes[0].last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      cipher_beat_type exp_beat;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected beat: out_byte %h final_out %b", rsp_out_byte, rsp_final_out);
               error_count++;
            end else begin
               exp_beat = expected_bytes.pop_front();
               if (rsp_out_byte !== exp_beat.data) begin
                  $error("out_byte: expected %h, actual %h", exp_beat.data, rsp_out_byte);
                  error_count++;
               end
               if (rsp_final_out !== exp_beat.last) begin
                  $error("final_out: expected %b, actual %b", exp_beat.last, rsp_final_out);
                  error_count++;
               end
            end
         end
         rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("aes128_ctr_stream_cipher_test: errors");
         $finish;
      end
   end

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      csr_shadow[idx] = value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || expected_bytes.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic push_beat(input logic [7:0] data, input logic last);
      cipher_beat_type b;
      b.data = data;
      b.last = last;
      pending_bytes.push_back(b);
   endtask

   initial begin
      int unsigned msg_left;
      int unsigned idle_plan[5];
      int unsigned stall_plan[5];
      idle_plan = '{0, 60, 0, 18, 0};
      stall_plan = '{0, 0, 60, 18, 0};
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_KEY_HIGH;
      csr_data = '0;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_final_byte = 1'b0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 0;
      cycle_count = 0;
      error_count = 0;
      msg_open = 1'b0;
      key_pos = 4'd0;
      counter_block = '0;
      keystream_block = '0;
      for (int i = 0; i < 4; i++) csr_shadow[i] = '0;
      build_sbox();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // An all-ones nonce makes the counter wrap to zero after the first block.
      write_csr(CSR_KEY_HIGH, '1);
      write_csr(CSR_KEY_LOW, '1);
      write_csr(CSR_NONCE_HIGH, '1);
      write_csr(CSR_NONCE_LOW, '1);
      push_beat(8'h00, 1'b1);
      for (int i = 0; i < 20; i++) push_beat(i[0] ? 8'hff : 8'h00, i == 19);
      push_beat(8'h80, 1'b0);
      push_beat(8'h7f, 1'b0);
      push_beat(8'h55, 1'b1);

      msg_left = 0;
      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         send_idle_pct = 0;
         recv_stall_pct = 0;
         case (ph)
            0: begin
               write_csr(CSR_KEY_HIGH, '0);
               write_csr(CSR_KEY_LOW, '0);
               write_csr(CSR_NONCE_HIGH, '0);
               write_csr(CSR_NONCE_LOW, '0);
            end
            2: begin
               write_csr(CSR_KEY_HIGH, {$urandom, $urandom});
               write_csr(CSR_NONCE_HIGH, {$urandom, $urandom});
               write_csr(CSR_NONCE_LOW, 64'hffff_ffff_ffff_fff0);
            end
            default: begin
               write_csr(CSR_KEY_HIGH, {$urandom, $urandom});
               write_csr(CSR_KEY_LOW, {$urandom, $urandom});
               write_csr(CSR_NONCE_HIGH, {$urandom, $urandom});
               write_csr(CSR_NONCE_LOW, {$urandom, $urandom});
            end
         endcase
         send_idle_pct = idle_plan[ph];
         recv_stall_pct = stall_plan[ph];
         if (ph == 4) begin
            @(negedge clock);
            hold_left = 400;
         end
         for (int n = 0; n < 306; n++) begin
            if (msg_left == 0)
               msg_left = ($urandom_range(9) == 0) ? $urandom_range(100, 1)
                                                   : $urandom_range(40, 1);
            msg_left--;
            push_beat($urandom_range(255), msg_left == 0);
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("aes128_ctr_stream_cipher_test: clean");
      end else begin
         $display("aes128_ctr_stream_cipher_test: errors");
      end
      $finish;
   end

endmodule
